>>> rtl/arlb_pkg.sv
// Shared types, constants and the threshold table of the auto-ranging level bar.
package arlb_pkg;

  // Number of bars on the display; the log scale is eight bars per octave.
  localparam int BAR_COUNT = 8;
  // At most sixteen thresholds are ever tested.
  localparam int BAR_LIMIT = (BAR_COUNT > 16) ? 16 : BAR_COUNT;
  localparam int CNT_W     = $clog2(BAR_COUNT + 1);
  localparam int K_W       = (BAR_LIMIT > 1) ? $clog2(BAR_LIMIT) : 1;

  // Field and datapath widths.
  localparam int IN_W      = 24;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam int LVL_W     = 32;
  localparam int THR_W     = 19;
  localparam int PROD_W    = LVL_W + THR_W;
  localparam int LHS_W     = LVL_W + 1 + 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FLOOR = 2'd1;

  // Reset values.
  localparam logic [CFG_W-1:0] MIN_LEVEL_RST = 24'd500;
  localparam logic [CFG_W-1:0] MAX_FLOOR_RST = 24'd15000;
  localparam logic [LVL_W-1:0] PEAK_RST      = 32'd3840000;

  // Q16 coefficients.
  localparam logic [THR_W-1:0] COEF_NEW    = 19'd26214;
  localparam logic [THR_W-1:0] COEF_OLD    = 19'd39322;
  localparam logic [THR_W-1:0] COEF_ATTACK = 19'd52429;
  localparam logic [THR_W-1:0] COEF_KEEP   = 19'd13107;
  localparam logic [THR_W-1:0] COEF_DECAY  = 19'd65470;
  localparam logic [PROD_W-1:0] ROUND_HALF = 51'd32768;

  // Datapath operations issued by the controller.
  typedef logic [3:0] dp_op_t;
  localparam dp_op_t OP_NONE     = 4'd0;
  localparam dp_op_t OP_LOAD     = 4'd1;
  localparam dp_op_t OP_SM_MUL1  = 4'd2;
  localparam dp_op_t OP_SM_MUL2  = 4'd3;
  localparam dp_op_t OP_SM_SUM   = 4'd4;
  localparam dp_op_t OP_AT_MUL1  = 4'd5;
  localparam dp_op_t OP_AT_MUL2  = 4'd6;
  localparam dp_op_t OP_AT_SUM   = 4'd7;
  localparam dp_op_t OP_DC_MUL   = 4'd8;
  localparam dp_op_t OP_DC_SHIFT = 4'd9;
  localparam dp_op_t OP_CNT_SET  = 4'd10;
  localparam dp_op_t OP_CNT_MUL  = 4'd11;
  localparam dp_op_t OP_CNT_STEP = 4'd12;
  localparam dp_op_t OP_OUT_LOAD = 4'd13;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic gt_peak;      // smoothed level above the tracked maximum
    logic above_floor;  // tracked maximum above the decay floor
    logic special;      // level at or below minimum, or degenerate range
    logic cmp_pass;     // current threshold test passes
    logic k_last;       // current threshold is the last one
  } dp_status_t;

  // Thresholds 2^(k/8) in Q16, for k = 1..16.
  function automatic logic [THR_W-1:0] thr_q16(input logic [3:0] idx);
    logic [THR_W-1:0] t;
    case (idx)
      4'd0:    t = 19'd71468;
      4'd1:    t = 19'd77936;
      4'd2:    t = 19'd84990;
      4'd3:    t = 19'd92682;
      4'd4:    t = 19'd101070;
      4'd5:    t = 19'd110218;
      4'd6:    t = 19'd120194;
      4'd7:    t = 19'd131072;
      4'd8:    t = 19'd142936;
      4'd9:    t = 19'd155872;
      4'd10:   t = 19'd169980;
      4'd11:   t = 19'd185364;
      4'd12:   t = 19'd202140;
      4'd13:   t = 19'd220436;
      4'd14:   t = 19'd240388;
      default: t = 19'd262144;
    endcase
    return t;
  endfunction

endpackage

>>> rtl/arlb_dpath.sv
// Datapath of the level bar: level registers, shared multiplier, accumulator and bar counter.
module arlb_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [arlb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [arlb_pkg::CFG_W-1:0]    cfg_data,
  input  logic [arlb_pkg::IN_W-1:0]     loudness,
  input  arlb_pkg::dp_cmd_t             cmd,
  output arlb_pkg::dp_status_t          status,
  output logic [3:0]                    bar_count,
  output logic [7:0]                    bar_mask,
  output logic [31:0]                   tracked_max
);
  import arlb_pkg::*;

  logic [CFG_W-1:0]  min_level;
  logic [CFG_W-1:0]  max_floor;
  logic [LVL_W-1:0]  lvl;
  logic [LVL_W-1:0]  smoothed;
  logic [LVL_W-1:0]  peak;
  logic [LVL_W-1:0]  diff;
  logic [LHS_W-1:0]  lhs;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] acc;
  logic [K_W-1:0]    k;
  logic [CNT_W-1:0]  n;

  logic [LVL_W-1:0]  min_fx;
  logic [LVL_W-1:0]  floor_fx;
  logic [PROD_W-1:0] sum;
  logic [K_W:0]      k_inc;
  logic              mul_en;
  logic [LVL_W-1:0]  mul_a;
  logic [THR_W-1:0]  mul_b;
  logic [CNT_W+3:0]  n_ext;

  assign min_fx   = {min_level, 8'd0};
  assign floor_fx = {max_floor, 8'd0};
  assign sum      = acc + prod;
  assign k_inc    = {1'b0, k} + 1'b1;

  // Status towards the controller.
  always_comb begin
    status.gt_peak     = smoothed > peak;
    status.above_floor = peak > floor_fx;
    status.special     = (smoothed <= min_fx) || (peak <= min_fx);
    status.cmp_pass    = {{(PROD_W-LHS_W){1'b0}}, lhs} >= prod;
    status.k_last      = k == K_W'(BAR_LIMIT - 1);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (cmd.op)
      OP_SM_MUL1: begin
        mul_en = 1'b1; mul_a = lvl;      mul_b = COEF_NEW;
      end
      OP_SM_MUL2: begin
        mul_en = 1'b1; mul_a = smoothed; mul_b = COEF_OLD;
      end
      OP_AT_MUL1: begin
        mul_en = 1'b1; mul_a = smoothed; mul_b = COEF_ATTACK;
      end
      OP_AT_MUL2: begin
        mul_en = 1'b1; mul_a = peak;     mul_b = COEF_KEEP;
      end
      OP_DC_MUL: begin
        mul_en = 1'b1; mul_a = peak;     mul_b = COEF_DECAY;
      end
      OP_CNT_MUL: begin
        mul_en = 1'b1; mul_a = diff;     mul_b = thr_q16(4'(k));
      end
      OP_CNT_STEP: begin
        mul_en = 1'b1; mul_a = diff;     mul_b = thr_q16(4'(k_inc));
      end
      default: begin
      end
    endcase
  end

  // Multiplier product register and rounding accumulator.
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (cmd.op == OP_SM_MUL2 || cmd.op == OP_AT_MUL2) begin
      acc <= prod + ROUND_HALF;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_level <= MIN_LEVEL_RST;
      max_floor <= MAX_FLOOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_LEVEL: min_level <= cfg_data;
        REG_MAX_FLOOR: max_floor <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Smoothed level and tracked maximum.
  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed <= '0;
      peak     <= PEAK_RST;
    end else begin
      if (cmd.op == OP_SM_SUM) begin
        smoothed <= sum[47:16];
      end
      if (cmd.op == OP_AT_SUM) begin
        peak <= sum[47:16];
      end else if (cmd.op == OP_DC_SHIFT) begin
        peak <= prod[47:16];
      end
    end
  end

  // Input latch and bar counting loop.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      lvl <= {loudness, 8'd0};
    end
    if (cmd.op == OP_CNT_SET) begin
      diff <= peak - min_fx;
      lhs  <= {(LVL_W'(peak - min_fx) + 33'(smoothed - min_fx)), 16'd0};
      k    <= '0;
      if (smoothed <= min_fx) begin
        n <= '0;
      end else if (peak <= min_fx) begin
        n <= CNT_W'(BAR_COUNT);
      end else begin
        n <= '0;
      end
    end
    if (cmd.op == OP_CNT_STEP) begin
      if (status.cmp_pass) begin
        n <= CNT_W'(k_inc);
      end
      k <= k_inc[K_W-1:0];
    end
  end

  // Result register.
  assign n_ext = {4'd0, n};
  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT_LOAD) begin
      bar_count   <= n_ext[3:0];
      tracked_max <= peak;
      for (int i = 0; i < 8; i++) begin
        bar_mask[i] <= n_ext > (CNT_W + 4)'(i);
      end
    end
  end

  // The count never passes the number of bars when it is loaded.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_OUT_LOAD |-> n <= CNT_W'(BAR_COUNT))
    else $error("bar count beyond bar number");

  // Decay never raises the tracked maximum.
  a_decay_down: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_DC_SHIFT |=> peak <= $past(peak))
    else $error("decay raised the tracked maximum");

  // Attack never lowers the tracked maximum.
  a_attack_up: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_AT_SUM |=> peak >= $past(peak))
    else $error("attack lowered the tracked maximum");

endmodule

>>> rtl/arlb_ctrl.sv
// Controller of the level bar: sequences the datapath and runs both handshakes.
module arlb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  arlb_pkg::dp_status_t status,
  output arlb_pkg::dp_cmd_t    cmd
);
  import arlb_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SM1   = 4'd1;
  localparam logic [3:0] ST_SM2   = 4'd2;
  localparam logic [3:0] ST_SM3   = 4'd3;
  localparam logic [3:0] ST_PK    = 4'd4;
  localparam logic [3:0] ST_AT1   = 4'd5;
  localparam logic [3:0] ST_AT2   = 4'd6;
  localparam logic [3:0] ST_AT3   = 4'd7;
  localparam logic [3:0] ST_DC1   = 4'd8;
  localparam logic [3:0] ST_DC2   = 4'd9;
  localparam logic [3:0] ST_CSET  = 4'd10;
  localparam logic [3:0] ST_CMUL  = 4'd11;
  localparam logic [3:0] ST_CSTEP = 4'd12;
  localparam logic [3:0] ST_OUT   = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_valid_next;

  assign in_ready = state == ST_IDLE;

  // Next state and datapath command.
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = ST_SM1;
        end
      end
      ST_SM1: begin
        cmd.op = OP_SM_MUL1; state_next = ST_SM2;
      end
      ST_SM2: begin
        cmd.op = OP_SM_MUL2; state_next = ST_SM3;
      end
      ST_SM3: begin
        cmd.op = OP_SM_SUM;  state_next = ST_PK;
      end
      ST_PK: begin
        if (status.gt_peak) begin
          state_next = ST_AT1;
        end else if (status.above_floor) begin
          state_next = ST_DC1;
        end else begin
          state_next = ST_CSET;
        end
      end
      ST_AT1: begin
        cmd.op = OP_AT_MUL1; state_next = ST_AT2;
      end
      ST_AT2: begin
        cmd.op = OP_AT_MUL2; state_next = ST_AT3;
      end
      ST_AT3: begin
        cmd.op = OP_AT_SUM;  state_next = ST_CSET;
      end
      ST_DC1: begin
        cmd.op = OP_DC_MUL;  state_next = ST_DC2;
      end
      ST_DC2: begin
        cmd.op = OP_DC_SHIFT; state_next = ST_CSET;
      end
      ST_CSET: begin
        cmd.op     = OP_CNT_SET;
        state_next = status.special ? ST_OUT : ST_CMUL;
      end
      ST_CMUL: begin
        cmd.op = OP_CNT_MUL; state_next = ST_CSTEP;
      end
      ST_CSTEP: begin
        cmd.op = OP_CNT_STEP;
        if (!status.cmp_pass || status.k_last) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.op     = OP_OUT_LOAD;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Result valid flag: set on load, cleared when the item is taken.
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.op == OP_OUT_LOAD) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // A new result is never loaded over one still waiting.
  a_no_clobber: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_OUT_LOAD |-> (!out_valid || out_ready))
    else $error("result overwritten before it was taken");

  // The counting loop leaves after the last threshold.
  a_loop_exit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CSTEP && status.k_last) |=> state == ST_OUT)
    else $error("threshold loop ran past its end");

  // An accepted item starts the smoothing sequence.
  a_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_SM1 && !in_ready))
    else $error("accepted item did not start processing");

endmodule

>>> rtl/auto_ranging_log_level_bar.sv
// Top level of the auto-ranging logarithmic level bar.
//
// One loudness item comes in per frame on in_valid/in_ready; one result item
// (bar count, thermometer bar mask and the tracked maximum) leaves on
// out_valid/out_ready. The smoothed level and the adaptive maximum are
// updated with a single shared 32x19 multiplier, and the bar count is found
// by testing the constant thresholds one per cycle against that multiplier.
// The next item can be taken in the cycle after a result has been loaded
// into the output register; a new item is not accepted while one is still
// being processed. Reset clears the smoothed level, sets the maximum to
// 15000.0 and restores both configuration registers; the user is to write
// them on cfg_we only at idle time, and the block itself does not enforce it.
// When the receiver stalls, the finished result is held in the output
// register and a new item is accepted and processed; it then waits before its
// result stage until the held result has been taken.
module auto_ranging_log_level_bar (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [arlb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [arlb_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [arlb_pkg::IN_W-1:0]      loudness,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [3:0]                     bar_count,
  output logic [7:0]                     bar_mask,
  output logic [31:0]                    tracked_max
);
  import arlb_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer and handshakes.
  arlb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic and result registers.
  arlb_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .loudness    (loudness),
    .cmd         (cmd),
    .status      (status),
    .bar_count   (bar_count),
    .bar_mask    (bar_mask),
    .tracked_max (tracked_max)
  );

endmodule
